### hw/rtl/tcp2_pkg.sv
// ----------------------------------------------------------------------------
// tcp2_pkg
// Shared types and constants of the two-endpoint TCP handshake unit.
// ----------------------------------------------------------------------------
package tcp2_pkg;

  // Client receive store size in bytes; the byte count itself is 12 bits wide.
  localparam int RX_CAPACITY = 4096;
  localparam int RX_SUM_W    = 17;  // payload length (16b) plus byte count (12b)

  // Depth of the step queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // TCP flag bits
  localparam logic [7:0] FL_FIN = 8'h01;
  localparam logic [7:0] FL_SYN = 8'h02;
  localparam logic [7:0] FL_PSH = 8'h08;
  localparam logic [7:0] FL_ACK = 8'h10;

  // Config register indexes
  localparam logic [2:0] CFG_LOOPBACK    = 3'd0;
  localparam logic [2:0] CFG_SERVER_PORT = 3'd1;
  localparam logic [2:0] CFG_CLIENT_PORT = 3'd2;
  localparam logic [2:0] CFG_SERVER_ISS  = 3'd3;
  localparam logic [2:0] CFG_CLIENT_ISS  = 3'd4;
  localparam logic [2:0] CFG_RESP_LEN    = 3'd5;

  typedef enum logic [1:0] {
    OP_SEGMENT = 2'd0,
    OP_CONNECT = 2'd1,
    OP_SEND    = 2'd2,
    OP_REINIT  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    PSRC_NONE     = 2'd0,
    PSRC_RESPONSE = 2'd1,
    PSRC_SEND     = 2'd2
  } psrc_t;

  // Input item, first field in the low bits.
  typedef struct packed {
    logic [15:0] packet_len;
    logic [3:0]  tcp_offset_words;
    logic [3:0]  ip_header_words;
    logic [7:0]  tcp_flags;
    logic [31:0] ack_num;
    logic [31:0] seq_num;
    logic [15:0] dst_port;
    logic [15:0] src_port;
    logic [31:0] dst_ip;
    logic [31:0] src_ip;
  } in_item_t;

  // Result item without the last marker, first field in the low bits.
  typedef struct packed {
    logic        status;
    logic [11:0] rx_count;
    logic        store_payload;
    psrc_t       payload_source;
    logic [7:0]  out_flags;
    logic [31:0] out_ack;
    logic [31:0] out_seq;
    logic [15:0] out_dst_port;
    logic [15:0] out_src_port;
    logic [31:0] out_dst_ip;
    logic [31:0] out_src_ip;
  } result_t;

  // One processed input item: its first result, and whether the canned
  // response segment follows it.
  typedef struct packed {
    logic    two;
    result_t res;
  } step_t;

endpackage

### hw/rtl/tcp_two_endpoint_handshake_unit.sv
// ----------------------------------------------------------------------------
// tcp_two_endpoint_handshake_unit
// One server and one client TCP endpoint driven by events; emits outgoing
// segment descriptors for outside checksum and assembly units.
// ----------------------------------------------------------------------------
// Path: an accepted item is written into the step queue, then loaded into
//   the output register. Throughput: one item per cycle while the 4-entry
//   step queue has room; results leave one per cycle while m_tready is high,
//   so a two-result step (server answer to a request) gives ACK, then response.
// Reset: synchronous; endpoints go to listen/closed, counters to zero, config
//   registers to their defaults, queue and output register empty.
// ----------------------------------------------------------------------------
module tcp_two_endpoint_handshake_unit import tcp2_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  // event input
  input  logic         s_tvalid,
  output logic         s_tready,
  // src_ip, dst_ip, src_port, dst_port, seq_num, ack_num, tcp_flags,
  // ip_header_words, tcp_offset_words, packet_len
  input  logic [191:0] s_tdata,
  // opcode
  input  logic [1:0]   s_tuser,
  // result output
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_src_ip, out_dst_ip, out_src_port, out_dst_port, out_seq, out_ack,
  // out_flags, payload_source, store_payload, rx_count, status
  output logic [183:0] m_tdata,
  output logic         m_tlast,
  // config write port
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  step_t   push_data;
  step_t   head;
  logic    push, q_full, q_valid, pop;
  result_t out_res;

  // Front: config, endpoint state and event decode; one step record per item.
  tcp2_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (in_item_t'(s_tdata)),
    .in_op     (s_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  // Queue lets the front keep accepting while results wait downstream.
  tcp2_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .valid     (q_valid)
  );

  // Back: expands records into results through the output register.
  tcp2_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_valid   (q_valid),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res),
    .out_last  (m_tlast)
  );

  assign m_tdata = out_res;

endmodule

### hw/rtl/tcp2_front.sv
// ----------------------------------------------------------------------------
// tcp2_front
// Accepts events, holds config and endpoint state, builds one step record per
// event and pushes it into the step queue.
// ----------------------------------------------------------------------------
module tcp2_front import tcp2_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  in_item_t      in_item,
  input  logic [1:0]    in_op,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  output logic          push,
  output step_t         push_data,
  input  logic          q_full
);

  typedef enum logic [2:0] {
    CONN_CLOSED   = 3'd0,
    CONN_LISTEN   = 3'd1,
    CONN_SYN_SENT = 3'd2,
    CONN_SYN_RCVD = 3'd3,
    CONN_ESTAB    = 3'd4
  } conn_state_t;

  // config
  logic [31:0] loopback;
  logic [15:0] srv_lport;
  logic [15:0] cli_lport;
  logic [31:0] srv_iss;
  logic [31:0] cli_iss;
  logic [10:0] resp_len;

  // endpoint state
  conn_state_t srv_state, srv_state_next;
  conn_state_t cli_state, cli_state_next;
  logic [31:0] srv_rcv_next, srv_rcv_next_next;
  logic [31:0] srv_snd_next, srv_snd_next_next;
  logic [31:0] cli_rcv_next, cli_rcv_next_next;
  logic [31:0] cli_snd_next, cli_snd_next_next;
  logic [11:0] rx_bytes, rx_bytes_next;

  // header length checks
  logic [5:0]          ihl_bytes;
  logic [5:0]          off_bytes;
  logic [6:0]          hdr_min;
  logic [15:0]         tlen;
  logic [15:0]         plen;
  logic                seg_ok;
  logic [RX_SUM_W-1:0] rx_sum;
  logic                rx_fit;
  logic [31:0]         seq_p1;
  logic [31:0]         seq_pl;
  logic                f_syn, f_ack, f_psh, f_fin;
  logic                srv_hit, cli_hit;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  assign ihl_bytes = {in_item.ip_header_words, 2'b00};
  assign off_bytes = {in_item.tcp_offset_words, 2'b00};
  assign hdr_min   = {1'b0, ihl_bytes} + 7'd20;
  assign tlen      = in_item.packet_len - {10'd0, ihl_bytes};
  assign plen      = tlen - {10'd0, off_bytes};
  assign seg_ok    = !(in_item.packet_len < {9'd0, hdr_min}) &&
                     !(off_bytes < 6'd20) && !(tlen < {10'd0, off_bytes});
  assign rx_sum    = {1'b0, plen} + {5'd0, rx_bytes};
  assign rx_fit    = rx_sum < RX_SUM_W'(RX_CAPACITY);
  assign seq_p1    = in_item.seq_num + 32'd1;
  assign seq_pl    = in_item.seq_num + {16'd0, plen};

  assign f_syn   = |(in_item.tcp_flags & FL_SYN);
  assign f_ack   = |(in_item.tcp_flags & FL_ACK);
  assign f_psh   = |(in_item.tcp_flags & FL_PSH);
  assign f_fin   = |(in_item.tcp_flags & FL_FIN);
  assign srv_hit = in_item.dst_port == srv_lport;
  assign cli_hit = in_item.dst_port == cli_lport;

  always_comb begin
    srv_state_next    = srv_state;
    cli_state_next    = cli_state;
    srv_rcv_next_next = srv_rcv_next;
    srv_snd_next_next = srv_snd_next;
    cli_rcv_next_next = cli_rcv_next;
    cli_snd_next_next = cli_snd_next;
    rx_bytes_next     = rx_bytes;
    push_data         = '0;

    unique case (opcode_t'(in_op))
      OP_SEGMENT: begin
        if (seg_ok) begin
          priority if (srv_hit && srv_state == CONN_LISTEN && f_syn && !f_ack) begin
            srv_state_next              = CONN_SYN_RCVD;
            srv_rcv_next_next           = seq_p1;
            srv_snd_next_next           = srv_iss + 32'd1;
            push_data.res.out_src_ip    = in_item.dst_ip;
            push_data.res.out_dst_ip    = in_item.src_ip;
            push_data.res.out_src_port  = srv_lport;
            push_data.res.out_dst_port  = in_item.src_port;
            push_data.res.out_seq       = srv_iss;
            push_data.res.out_ack       = seq_p1;
            push_data.res.out_flags     = FL_SYN | FL_ACK;
          end else if (srv_hit && srv_state == CONN_SYN_RCVD && f_ack && !f_syn) begin
            if (in_item.ack_num == srv_snd_next) begin
              srv_state_next    = CONN_ESTAB;
              srv_rcv_next_next = seq_p1;
            end
          end else if (srv_hit && srv_state == CONN_ESTAB && f_psh) begin
            // ACK now, canned response follows as the second result
            srv_rcv_next_next           = seq_pl;
            srv_snd_next_next           = srv_snd_next + {21'd0, resp_len};
            srv_state_next              = CONN_CLOSED;
            push_data.two               = 1'b1;
            push_data.res.out_src_ip    = in_item.dst_ip;
            push_data.res.out_dst_ip    = in_item.src_ip;
            push_data.res.out_src_port  = srv_lport;
            push_data.res.out_dst_port  = in_item.src_port;
            push_data.res.out_seq       = srv_snd_next;
            push_data.res.out_ack       = seq_pl;
            push_data.res.out_flags     = FL_ACK;
          end else if (cli_hit && cli_state == CONN_SYN_SENT && f_syn && f_ack) begin
            cli_rcv_next_next           = seq_p1;
            cli_snd_next_next           = in_item.ack_num;
            cli_state_next              = CONN_ESTAB;
            push_data.res.out_src_ip    = in_item.dst_ip;
            push_data.res.out_dst_ip    = in_item.src_ip;
            push_data.res.out_src_port  = cli_lport;
            push_data.res.out_dst_port  = in_item.src_port;
            push_data.res.out_seq       = in_item.ack_num;
            push_data.res.out_ack       = seq_p1;
            push_data.res.out_flags     = FL_ACK;
          end else if (cli_hit && cli_state == CONN_ESTAB && f_psh) begin
            // full store drops the payload but still acks it
            if (rx_fit) begin
              rx_bytes_next               = rx_sum[11:0];
              push_data.res.store_payload = 1'b1;
            end
            cli_rcv_next_next           = seq_pl;
            push_data.res.out_src_ip    = in_item.dst_ip;
            push_data.res.out_dst_ip    = in_item.src_ip;
            push_data.res.out_src_port  = cli_lport;
            push_data.res.out_dst_port  = in_item.src_port;
            push_data.res.out_seq       = cli_snd_next;
            push_data.res.out_ack       = seq_pl;
            push_data.res.out_flags     = FL_ACK;
          end else if (cli_hit && cli_state == CONN_ESTAB && f_fin) begin
            cli_state_next = CONN_CLOSED;
          end else begin
            // segment ignored
          end
        end
      end
      OP_CONNECT: begin
        cli_state_next              = CONN_SYN_SENT;
        cli_snd_next_next           = cli_iss + 32'd1;
        rx_bytes_next               = '0;
        srv_state_next              = CONN_LISTEN;
        push_data.res.out_src_ip    = loopback;
        push_data.res.out_dst_ip    = loopback;
        push_data.res.out_src_port  = cli_lport;
        push_data.res.out_dst_port  = srv_lport;
        push_data.res.out_seq       = cli_iss;
        push_data.res.out_flags     = FL_SYN;
      end
      OP_SEND: begin
        if (cli_state != CONN_ESTAB) begin
          push_data.res.status = 1'b1;
        end else begin
          push_data.res.out_src_ip     = loopback;
          push_data.res.out_dst_ip     = loopback;
          push_data.res.out_src_port   = cli_lport;
          push_data.res.out_dst_port   = srv_lport;
          push_data.res.out_seq        = cli_snd_next;
          push_data.res.out_ack        = cli_rcv_next;
          push_data.res.out_flags      = FL_ACK | FL_PSH;
          push_data.res.payload_source = PSRC_SEND;
          cli_snd_next_next            = cli_snd_next + {16'd0, in_item.packet_len};
        end
      end
      OP_REINIT: begin
        srv_state_next = CONN_LISTEN;
        cli_state_next = CONN_CLOSED;
        rx_bytes_next  = '0;
      end
    endcase

    push_data.res.rx_count = rx_bytes_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      srv_state    <= CONN_LISTEN;
      cli_state    <= CONN_CLOSED;
      srv_rcv_next <= '0;
      srv_snd_next <= '0;
      cli_rcv_next <= '0;
      cli_snd_next <= '0;
      rx_bytes     <= '0;
      loopback     <= 32'd2130706433;
      srv_lport    <= 16'd80;
      cli_lport    <= 16'd49152;
      srv_iss      <= 32'd50000;
      cli_iss      <= 32'd10000;
      resp_len     <= 11'd169;
    end else begin
      if (push) begin
        srv_state    <= srv_state_next;
        cli_state    <= cli_state_next;
        srv_rcv_next <= srv_rcv_next_next;
        srv_snd_next <= srv_snd_next_next;
        cli_rcv_next <= cli_rcv_next_next;
        cli_snd_next <= cli_snd_next_next;
        rx_bytes     <= rx_bytes_next;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LOOPBACK:    loopback  <= cfg_data;
          CFG_SERVER_PORT: srv_lport <= cfg_data[15:0];
          CFG_CLIENT_PORT: cli_lport <= cfg_data[15:0];
          CFG_SERVER_ISS:  srv_iss   <= cfg_data;
          CFG_CLIENT_ISS:  cli_iss   <= cfg_data;
          CFG_RESP_LEN:    resp_len  <= cfg_data[10:0];
          default: ;
        endcase
      end
    end
  end

endmodule

### hw/rtl/tcp2_queue.sv
// ----------------------------------------------------------------------------
// tcp2_queue
// Small FIFO of step records between front and back.
// ----------------------------------------------------------------------------
module tcp2_queue import tcp2_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  step_t push_data,
  output logic  full,
  input  logic  pop,
  output step_t head,
  output logic  valid
);

  step_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = count == QCNT_W'(QUEUE_DEPTH);
  assign valid = count != '0;
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/tcp2_back.sv
// ----------------------------------------------------------------------------
// tcp2_back
// Drains step records into result items; a two-result step gives its ACK
// first and the canned response segment next.
// ----------------------------------------------------------------------------
module tcp2_back import tcp2_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  step_t   head,
  input  logic    q_valid,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res,
  output logic    out_last
);

  logic    phase;  // second result of the head step is next
  logic    load;
  result_t load_res;

  assign load = q_valid && (!out_valid || out_ready);
  assign pop  = load && (phase || !head.two);

  // second pass over a two-result step turns the ACK into the response
  always_comb begin
    load_res = head.res;
    if (phase) begin
      load_res.out_flags      = FL_ACK | FL_PSH;
      load_res.payload_source = PSRC_RESPONSE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        phase     <= head.two && !phase;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res  <= load_res;
      out_last <= !(head.two && !phase);
    end
  end

  // head step stays queued until its second result is out
  a_phase_has_head: assert property (@(posedge clk) disable iff (rst)
    phase |-> q_valid)
    else $error("second result pending with empty queue");

  // a non-final result is always the ACK of a two-result step
  a_first_sets_phase: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_last) |-> phase)
    else $error("non-final result without pending second result");

  a_first_is_ack: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_last) |-> (out_res.out_flags == FL_ACK))
    else $error("non-final result is not a plain ACK");

  a_second_follows: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_last && out_ready) |=> (out_valid && out_last))
    else $error("response segment did not follow its ACK");

endmodule

### verif/tcp_two_endpoint_handshake_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_two_endpoint_handshake_unit_test
// Self-checking bench for the two-endpoint TCP handshake unit. A queue-fed
// driver offers events, an in-bench endpoint model predicts every outgoing
// segment descriptor, and a monitor compares each result field by field.
// Covers directed corner cases, server and client sessions with random
// content, noise events, several register settings and random back-pressure.
// ----------------------------------------------------------------------------
module tcp_two_endpoint_handshake_unit_test;
  import tcp2_pkg::*;

  // endpoint states of the in-bench model
  typedef enum logic [2:0] {
    EP_CLOSED      = 3'd0,
    EP_LISTEN      = 3'd1,
    EP_SYN_SENT    = 3'd2,
    EP_SYN_RCVD    = 3'd3,
    EP_ESTABLISHED = 3'd4
  } ep_state_t;

  // one event as offered on the input stream
  typedef struct packed {
    opcode_t  op;
    in_item_t d;
  } event_t;

  // one predicted result with its end-of-step marker
  typedef struct packed {
    logic    last;
    result_t res;
  } expect_t;

  // --------------------------------------------------------------------------
  // DUT ports
  // --------------------------------------------------------------------------
  logic         clk       = 1'b0;
  logic         rst       = 1'b1;
  logic         s_tvalid  = 1'b0;
  logic         s_tready;
  logic [191:0] s_tdata   = '0;
  logic [1:0]   s_tuser   = '0;
  logic         m_tvalid;
  logic         m_tready  = 1'b0;
  logic [183:0] m_tdata;
  logic         m_tlast;
  logic         cfg_we    = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_data  = '0;

  tcp_two_endpoint_handshake_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Register shadow (reset values) and endpoint model state
  // --------------------------------------------------------------------------
  logic [31:0] lb_addr   = 32'd2130706433;
  logic [15:0] srv_lport = 16'd80;
  logic [15:0] cli_lport = 16'd49152;
  logic [31:0] srv_iss   = 32'd50000;
  logic [31:0] cli_iss   = 32'd10000;
  logic [10:0] resp_len  = 11'd169;

  ep_state_t   srv_state = EP_LISTEN;
  ep_state_t   cli_state = EP_CLOSED;
  logic [31:0] srv_rcv = '0, srv_snd = '0;
  logic [31:0] cli_rcv = '0, cli_snd = '0;
  logic [11:0] cli_rx  = '0;

  // --------------------------------------------------------------------------
  // Bench bookkeeping
  // --------------------------------------------------------------------------
  event_t  events_pending[$];   // events not yet offered
  expect_t segments_due[$];     // predicted results, oldest first
  event_t  cur_event;
  logic    offering;
  int      tx_hold = 0, rx_hold = 0;
  int      tx_idle = 20, rx_idle = 20;   // percent chance of starting a gap
  logic    long_stall = 1'b0;

  int submitted_count = 0, accepted_count = 0;
  int results_checked = 0, mismatches = 0;
  int n_two = 0, n_store = 0, n_refused = 0, n_settings = 1;

  // --------------------------------------------------------------------------
  // Random helpers
  // --------------------------------------------------------------------------
  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int idle_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 10;
      2:       return 30;
      default: return 60;
    endcase
  endfunction

  function automatic logic [31:0] rand32();
    case ($urandom_range(0, 9))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_payload();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(0, 64);
    if (r < 85) return $urandom_range(65, 600);
    if (r < 97) return $urandom_range(601, 3000);
    return $urandom_range(3001, 20000);
  endfunction

  // well-formed segment header toward a port, random addresses and lengths
  function automatic event_t seg_to(input logic [15:0] port, input logic [7:0] fl,
                                    input logic [31:0] sq, input logic [31:0] ak,
                                    input int plen);
    event_t e;
    int     hw, ow, total;
    e.op          = OP_SEGMENT;
    e.d.src_ip    = rand32();
    e.d.dst_ip    = rand32();
    e.d.src_port  = 16'($urandom);
    e.d.dst_port  = port;
    e.d.seq_num   = sq;
    e.d.ack_num   = ak;
    e.d.tcp_flags = fl;
    hw = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
    ow = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
    total = hw * 4 + ow * 4 + plen;
    if (total > 65535) total = 65535;
    e.d.ip_header_words  = 4'(hw);
    e.d.tcp_offset_words = 4'(ow);
    e.d.packet_len       = 16'(total);
    return e;
  endfunction

  // non-segment event; header fields are random and must not matter
  function automatic event_t op_ev(input opcode_t op, input logic [15:0] len);
    event_t e;
    e.d = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    e.op = op;
    e.d.packet_len = len;
    return e;
  endfunction

  function automatic result_t make_seg(input logic [31:0] sip, input logic [31:0] dip,
                                       input logic [15:0] sp, input logic [15:0] dp,
                                       input logic [31:0] sq, input logic [31:0] ak,
                                       input logic [7:0] fl, input psrc_t src);
    result_t r;
    r = '0;
    r.out_src_ip     = sip;
    r.out_dst_ip     = dip;
    r.out_src_port   = sp;
    r.out_dst_port   = dp;
    r.out_seq        = sq;
    r.out_ack        = ak;
    r.out_flags      = fl;
    r.payload_source = src;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Endpoint model: advances state for one accepted event and queues the
  // segment descriptors it produces.
  // --------------------------------------------------------------------------
  task automatic advance_endpoints(input event_t ev);
    logic [31:0] hdr, off, tot, plen;
    logic [7:0]  fl;
    result_t     first, second;
    expect_t     want;
    int          n;
    logic        stored, refused, taken;
    first = '0;
    second = '0;
    n = 0;
    stored = 1'b0;
    refused = 1'b0;
    taken = 1'b0;
    fl = ev.d.tcp_flags;
    case (ev.op)
      OP_SEGMENT: begin
        hdr = {26'd0, ev.d.ip_header_words, 2'b00};
        off = {26'd0, ev.d.tcp_offset_words, 2'b00};
        tot = {16'd0, ev.d.packet_len};
        // short packet or bad data offset: silently dropped
        if (tot >= hdr + 32'd20 && off >= 32'd20 && (tot - hdr) >= off) begin
          plen = tot - hdr - off;
          // server rules first, so equal ports favor the server
          if (ev.d.dst_port == srv_lport) begin
            if (srv_state == EP_LISTEN && (fl & FL_SYN) != 0 && (fl & FL_ACK) == 0) begin
              srv_state = EP_SYN_RCVD;
              srv_rcv = ev.d.seq_num + 32'd1;
              srv_snd = srv_iss + 32'd1;
              first = make_seg(ev.d.dst_ip, ev.d.src_ip, srv_lport, ev.d.src_port,
                               srv_iss, srv_rcv, FL_SYN | FL_ACK, PSRC_NONE);
              n = 1;
              taken = 1'b1;
            end else if (srv_state == EP_SYN_RCVD && (fl & FL_ACK) != 0 &&
                         (fl & FL_SYN) == 0) begin
              // wrong ack number keeps syn_rcvd
              if (ev.d.ack_num == srv_snd) begin
                srv_state = EP_ESTABLISHED;
                srv_rcv = ev.d.seq_num + 32'd1;
              end
              taken = 1'b1;
            end else if (srv_state == EP_ESTABLISHED && (fl & FL_PSH) != 0) begin
              // request: plain ack, then the canned response, then close
              srv_rcv = ev.d.seq_num + plen;
              first = make_seg(ev.d.dst_ip, ev.d.src_ip, srv_lport, ev.d.src_port,
                               srv_snd, srv_rcv, FL_ACK, PSRC_NONE);
              second = make_seg(ev.d.dst_ip, ev.d.src_ip, srv_lport, ev.d.src_port,
                                srv_snd, srv_rcv, FL_ACK | FL_PSH, PSRC_RESPONSE);
              srv_snd = srv_snd + {21'd0, resp_len};
              srv_state = EP_CLOSED;
              n = 2;
              taken = 1'b1;
            end
          end
          if (!taken && ev.d.dst_port == cli_lport) begin
            if (cli_state == EP_SYN_SENT && (fl & FL_SYN) != 0 && (fl & FL_ACK) != 0) begin
              cli_rcv = ev.d.seq_num + 32'd1;
              cli_snd = ev.d.ack_num;
              first = make_seg(ev.d.dst_ip, ev.d.src_ip, cli_lport, ev.d.src_port,
                               cli_snd, cli_rcv, FL_ACK, PSRC_NONE);
              cli_state = EP_ESTABLISHED;
              n = 1;
            end else if (cli_state == EP_ESTABLISHED && (fl & FL_PSH) != 0) begin
              // full store: payload dropped but still acked
              if (plen + {20'd0, cli_rx} < RX_CAPACITY) begin
                cli_rx = cli_rx + plen[11:0];
                stored = 1'b1;
              end
              cli_rcv = ev.d.seq_num + plen;
              first = make_seg(ev.d.dst_ip, ev.d.src_ip, cli_lport, ev.d.src_port,
                               cli_snd, cli_rcv, FL_ACK, PSRC_NONE);
              n = 1;
            end else if (cli_state == EP_ESTABLISHED && (fl & FL_FIN) != 0) begin
              cli_state = EP_CLOSED;
            end
          end
        end
      end
      OP_CONNECT: begin
        cli_state = EP_SYN_SENT;
        cli_snd = cli_iss + 32'd1;
        cli_rx = '0;
        srv_state = EP_LISTEN;
        first = make_seg(lb_addr, lb_addr, cli_lport, srv_lport, cli_iss, 32'd0,
                         FL_SYN, PSRC_NONE);
        n = 1;
      end
      OP_SEND: begin
        if (cli_state != EP_ESTABLISHED) begin
          refused = 1'b1;
        end else begin
          first = make_seg(lb_addr, lb_addr, cli_lport, srv_lport, cli_snd, cli_rcv,
                           FL_ACK | FL_PSH, PSRC_SEND);
          cli_snd = cli_snd + {16'd0, ev.d.packet_len};
          n = 1;
        end
      end
      default: begin  // reinitialise; sequence numbers and registers stay
        srv_state = EP_LISTEN;
        cli_state = EP_CLOSED;
        cli_rx = '0;
      end
    endcase

    if (n == 0) n = 1;  // no-segment result
    first.store_payload  = stored;
    first.rx_count       = cli_rx;
    first.status         = refused;
    second.store_payload = stored;
    second.rx_count      = cli_rx;
    second.status        = refused;
    want.last = (n == 1);
    want.res  = first;
    segments_due.push_back(want);
    if (n == 2) begin
      want.last = 1'b1;
      want.res  = second;
      segments_due.push_back(want);
      n_two++;
    end
    if (stored) n_store++;
    if (refused) n_refused++;
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  task automatic flag_mismatch(input string why, input expect_t want,
                               input result_t got, input logic got_last);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s at result %0d", $time, why, results_checked);
      $display("  want ip %h>%h port %h>%h seq %h ack %h fl %h",
               want.res.out_src_ip, want.res.out_dst_ip, want.res.out_src_port,
               want.res.out_dst_port, want.res.out_seq, want.res.out_ack,
               want.res.out_flags);
      $display("       src %0d sto %b rx %0d ref %b last %b",
               want.res.payload_source, want.res.store_payload,
               want.res.rx_count, want.res.status, want.last);
      $display("  got  ip %h>%h port %h>%h seq %h ack %h fl %h",
               got.out_src_ip, got.out_dst_ip, got.out_src_port, got.out_dst_port,
               got.out_seq, got.out_ack, got.out_flags);
      $display("       src %0d sto %b rx %0d ref %b last %b",
               got.payload_source, got.store_payload, got.rx_count, got.status,
               got_last);
    end
  endtask

  task automatic check_result(input result_t got, input logic got_last);
    expect_t want;
    results_checked++;
    if (segments_due.size() == 0) begin
      want = '0;
      flag_mismatch("unexpected result", want, got, got_last);
    end else begin
      want = segments_due.pop_front();
      if (got.out_src_ip     !== want.res.out_src_ip     ||
          got.out_dst_ip     !== want.res.out_dst_ip     ||
          got.out_src_port   !== want.res.out_src_port   ||
          got.out_dst_port   !== want.res.out_dst_port   ||
          got.out_seq        !== want.res.out_seq        ||
          got.out_ack        !== want.res.out_ack        ||
          got.out_flags      !== want.res.out_flags      ||
          got.payload_source !== want.res.payload_source ||
          got.store_payload  !== want.res.store_payload  ||
          got.rx_count       !== want.res.rx_count       ||
          got.status         !== want.res.status         ||
          got_last           !== want.last)
        flag_mismatch("result differs", want, got, got_last);
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers queued events with random gaps between items
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_hold = 0;
    end else begin
      offering = s_tvalid;
      if (s_tvalid && s_tready) begin
        advance_endpoints(cur_event);
        accepted_count++;
        offering = 1'b0;
        tx_hold = ($urandom_range(0, 99) < tx_idle) ? gap_len() : 0;
      end
      if (!offering) begin
        if (tx_hold > 0) begin
          tx_hold--;
        end else if (events_pending.size() != 0) begin
          cur_event = events_pending.pop_front();
          s_tdata <= cur_event.d;
          s_tuser <= cur_event.op;
          offering = 1'b1;
        end
      end
      // single update per edge keeps back-to-back items glitch free
      s_tvalid <= offering;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: random ready stalls plus the long hold-off
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_hold = 0;
    end else begin
      if (m_tvalid && m_tready) check_result(m_tdata, m_tlast);
      if (rx_hold > 0) rx_hold--;
      else if ($urandom_range(0, 99) < rx_idle) rx_hold = gap_len();
      m_tready <= !long_stall && rx_hold == 0;
    end
  end

  // Long receiver hold-off while the sender keeps offering: the step queue
  // fills up and s_tready has to drop.
  initial begin
    wait (accepted_count >= 150);
    @(posedge clk);
    long_stall <= 1'b1;
    repeat (300) @(posedge clk);
    long_stall <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_ev(input event_t e);
    events_pending.push_back(e);
    submitted_count++;
  endtask

  // wait until every offered item is in and every result is out
  task automatic wait_idle();
    while (accepted_count != submitted_count || segments_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register write; the shadow is updated with it since the block is idle
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_LOOPBACK:    lb_addr   = val;
      CFG_SERVER_PORT: srv_lport = val[15:0];
      CFG_CLIENT_PORT: cli_lport = val[15:0];
      CFG_SERVER_ISS:  srv_iss   = val;
      CFG_CLIENT_ISS:  cli_iss   = val;
      CFG_RESP_LEN:    resp_len  = val[10:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input logic [31:0] lb, input logic [15:0] sp,
                            input logic [15:0] cp, input logic [31:0] siss,
                            input logic [31:0] ciss, input logic [10:0] rl);
    write_reg(CFG_LOOPBACK, lb);
    write_reg(CFG_SERVER_PORT, {16'd0, sp});
    write_reg(CFG_CLIENT_PORT, {16'd0, cp});
    write_reg(CFG_SERVER_ISS, siss);
    write_reg(CFG_CLIENT_ISS, ciss);
    write_reg(CFG_RESP_LEN, {21'd0, rl});
    n_settings++;
  endtask

  // corner cases at the reset register values
  task automatic run_directed();
    event_t e;
    push_ev(op_ev(OP_SEND, 16'hFFFF));             // send with client closed
    e = seg_to(srv_lport, FL_SYN, '0, '0, 0);
    e.d.ip_header_words = 4'd5;
    e.d.tcp_offset_words = 4'd5;
    e.d.packet_len = 16'd39;                        // one byte short
    push_ev(e);
    e.d.ip_header_words = 4'hF;
    e.d.packet_len = 16'd79;                        // short with longest IP header
    push_ev(e);
    e.d.ip_header_words = 4'd5;
    e.d.tcp_offset_words = 4'd4;                    // data offset below 20
    e.d.packet_len = 16'd40;
    push_ev(e);
    e.d.tcp_offset_words = 4'hF;                    // offset past the packet end
    e.d.packet_len = 16'd70;
    push_ev(e);
    e.d.ip_header_words = 4'd0;
    e.d.tcp_offset_words = 4'd0;
    e.d.packet_len = 16'd0;
    push_ev(e);
    // server handshake and request
    e = seg_to(srv_lport, FL_SYN, 32'hFFFF_FFFF, 32'h0, 0);
    e.d.src_ip = 32'h0;
    e.d.dst_ip = 32'hFFFF_FFFF;
    e.d.src_port = 16'hFFFF;
    push_ev(e);
    push_ev(seg_to(srv_lport, FL_SYN | FL_ACK, $urandom, srv_iss + 1, 0)); // not a rule
    push_ev(seg_to(srv_lport, FL_ACK, $urandom, srv_iss, 0));          // wrong ack
    push_ev(seg_to(srv_lport, FL_ACK, 32'h0, srv_iss + 1, 0));
    push_ev(seg_to(srv_lport, FL_PSH | FL_ACK, 32'hFFFF_FFF0, $urandom, 100));
    push_ev(seg_to(srv_lport, FL_PSH, $urandom, $urandom, 10));       // server closed now
    // client connection, data both ways, store filling up
    push_ev(op_ev(OP_CONNECT, 16'($urandom)));
    push_ev(seg_to(cli_lport, FL_SYN | FL_ACK, 32'hFFFF_FFFF, $urandom, 0));
    push_ev(op_ev(OP_SEND, 16'd1460));
    push_ev(seg_to(cli_lport, FL_PSH | FL_ACK, $urandom, $urandom, 4000));
    push_ev(seg_to(cli_lport, FL_PSH, $urandom, $urandom, 95));        // store at 4095
    push_ev(seg_to(cli_lport, FL_PSH, $urandom, $urandom, 1));         // store full
    push_ev(seg_to(cli_lport, FL_PSH, $urandom, $urandom, 0));
    push_ev(seg_to(cli_lport, FL_FIN | FL_ACK, $urandom, $urandom, 0));
    push_ev(op_ev(OP_SEND, 16'd0));
    push_ev(seg_to(cli_lport, FL_PSH, $urandom, $urandom, 20));        // client closed
    e.op = OP_SEGMENT;
    e.d = '1;                                       // every field at its top
    push_ev(e);
    push_ev(op_ev(OP_REINIT, 16'($urandom)));
    push_ev(op_ev(OP_CONNECT, 16'($urandom)));
    push_ev(op_ev(OP_SEND, 16'd5));                 // syn_sent, still refused
    push_ev(op_ev(OP_REINIT, 16'($urandom)));
  endtask

  // one random session: mostly well-formed exchanges, some noise
  task automatic push_session();
    event_t e;
    int     kind;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      // server: mostly bring it back to listen first, then SYN, ACK, request
      case ($urandom_range(0, 9))
        0, 1, 2, 3: push_ev(op_ev(OP_REINIT, 16'($urandom)));
        4, 5, 6:    push_ev(op_ev(OP_CONNECT, 16'($urandom)));
        default: ;
      endcase
      push_ev(seg_to(srv_lport, (8'($urandom) & ~FL_ACK) | FL_SYN, rand32(), rand32(),
                     pick_payload()));
      if ($urandom_range(0, 4) == 0)
        push_ev(seg_to(srv_lport, (8'($urandom) & ~FL_SYN) | FL_ACK, rand32(), rand32(),
                       pick_payload()));
      if ($urandom_range(0, 9) != 0)
        push_ev(seg_to(srv_lport, (8'($urandom) & ~FL_SYN) | FL_ACK, rand32(),
                       srv_iss + 1, pick_payload()));
      if ($urandom_range(0, 9) != 0)
        push_ev(seg_to(srv_lport, 8'($urandom) | FL_PSH, rand32(), rand32(),
                       pick_payload()));
    end else if (kind < 80) begin
      // client: connect, SYN+ACK, then sends and received data
      push_ev(op_ev(OP_CONNECT, 16'($urandom)));
      if ($urandom_range(0, 9) != 0)
        push_ev(seg_to(cli_lport, 8'($urandom) | FL_SYN | FL_ACK, rand32(), rand32(),
                       pick_payload()));
      repeat ($urandom_range(0, 6)) begin
        if ($urandom_range(0, 1) == 0)
          push_ev(op_ev(OP_SEND, 16'($urandom)));
        else
          push_ev(seg_to(cli_lport, 8'($urandom) | FL_PSH, rand32(), rand32(),
                         pick_payload()));
      end
      if ($urandom_range(0, 2) == 0) begin
        push_ev(seg_to(cli_lport, (8'($urandom) & ~FL_PSH) | FL_FIN, rand32(), rand32(),
                       0));
        if ($urandom_range(0, 1) == 0) push_ev(op_ev(OP_SEND, 16'($urandom)));
      end
    end else begin
      case ($urandom_range(0, 3))
        0: begin                                    // anything at all
          e.op = opcode_t'($urandom_range(0, 3));
          e.d = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
          push_ev(e);
        end
        1: begin                                    // truncated segment
          e = seg_to(($urandom_range(0, 1) == 0) ? srv_lport : cli_lport, 8'($urandom),
                     rand32(), rand32(), 0);
          e.d.packet_len = 16'($urandom_range(0, 19) + 4 * e.d.ip_header_words);
          push_ev(e);
        end
        2:       push_ev(op_ev(OP_REINIT, 16'($urandom)));
        default: push_ev(seg_to(16'($urandom), 8'($urandom), rand32(), rand32(),
                                pick_payload()));
      endcase
    end
  endtask

  task automatic random_phase(input int count, input int tx_pct, input int rx_pct);
    int target;
    tx_idle = tx_pct;
    rx_idle = rx_pct;
    target = submitted_count + count;
    while (submitted_count < target) push_session();
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [15:0] shared_port;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values
    run_directed();
    wait_idle();
    random_phase(250, 20, 20);

    // all registers at zero: equal ports, server wins
    set_config('0, '0, '0, '0, '0, '0);
    random_phase(200, idle_pct(), idle_pct());

    // all registers but the response length at the top of their range; ISS+1 wraps
    set_config(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 11'd1260);
    random_phase(200, idle_pct(), idle_pct());

    // random settings; one phase with no idling at all
    set_config($urandom, 16'($urandom), 16'($urandom), $urandom, $urandom,
               11'($urandom_range(0, 1260)));
    random_phase(200, 0, 0);
    set_config($urandom, 16'($urandom), 16'($urandom), $urandom, $urandom,
               11'($urandom_range(0, 1260)));
    random_phase(200, idle_pct(), idle_pct());

    shared_port = 16'($urandom);
    set_config($urandom, shared_port, shared_port, $urandom, $urandom,
               11'($urandom_range(0, 1260)));
    random_phase(150, idle_pct(), idle_pct());

    // back to the reset values, written explicitly
    set_config(32'd2130706433, 16'd80, 16'd49152, 32'd50000, 32'd10000, 11'd169);
    random_phase(200, idle_pct(), idle_pct());

    // drain and give stray results time to show up
    wait_idle();
    repeat (16) @(posedge clk);

    $display("ran %0d events over %0d register settings, %0d results compared",
             accepted_count, n_settings, results_checked);
    $display("%0d two-segment answers, %0d payload stores, %0d refused sends, %0d mismatches",
             n_two, n_store, n_refused, mismatches);
    if (mismatches == 0 && segments_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog: ends the run as a failure if it hangs
  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

endmodule
